/* sv/jrma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrma_pkg
// Shared widths, register indexes, reset values and the command and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package jrma_pkg;

    // Field widths
    localparam int SAMPLE_W = 32;            // signed Q16.16 sample
    localparam int CNT_W    = 4;             // fill count and window length
    localparam int THR_W    = 31;            // jump threshold
    // Sum of at most 15 samples
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int ITER_W   = $clog2(SUM_W + 1);

    // Default ring depth
    localparam int WINDOW_MAX_DEF = 8;

    // Configuration register indexes
    localparam logic CFG_WINDOW_LEN = 1'b0;
    localparam logic CFG_JUMP_THR   = 1'b1;

    // Configuration reset values (threshold is 0.01 in Q16.16, truncated)
    localparam logic [CNT_W-1:0] WIN_LEN_RST  = CNT_W'(8);
    localparam logic [THR_W-1:0] JUMP_THR_RST = THR_W'(655);

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming sample
        logic test;      // jump and drop decision, ring read of oldest entry
        logic update;    // ring write, sum and count update
        logic div_load;  // prime the serial divider
        logic div_step;  // one quotient bit
        logic out_load;  // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_last;  // final quotient bit in this cycle
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

/* sv/jrma_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrma_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module jrma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/jrma_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrma_ctrl
// Sequencer for one sample: jump test, window update, serial division and
// hand-over to the output register.
// ----------------------------------------------------------------------------
module jrma_ctrl
    import jrma_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_UPDATE,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_TEST;
                    n_ready       = 1'b0;
                end
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                n_state    = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                    n_ready        = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_ready = r_ready;

endmodule

/* sv/jrma_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrma_dp
// Datapath: configuration registers, sample ring, running sum, restoring
// divider and output register.
// ----------------------------------------------------------------------------
module jrma_dp
    import jrma_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [THR_W-1:0]           i_cfg_wdata,
    // input payload
    input  logic signed [SAMPLE_W-1:0] i_sample,
    // output channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_average,
    output logic [CNT_W-1:0]           o_fill_count,
    output logic                       o_restarted,
    // control
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts
);

    localparam int IDX_W   = $clog2(WINDOW_MAX);
    // Largest usable fill count: limited by ring depth and the 4-bit length
    localparam int CNT_MAX = (WINDOW_MAX < (2**CNT_W - 1)) ? WINDOW_MAX : (2**CNT_W - 1);
    localparam int ADD_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam int REM_W   = CNT_W + 1;

    // Configuration
    logic [CNT_W-1:0] r_win_len;
    logic [THR_W-1:0] r_jump_thr;

    // Window state
    logic signed [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]           r_count;
    logic [IDX_W-1:0]           r_oldest;
    logic signed [SAMPLE_W-1:0] r_newest;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_restart;
    logic                       r_drop;

    // Divider
    logic [SUM_W-1:0]  r_quo;
    logic [REM_W-1:0]  r_rem;
    logic              r_neg;
    logic [ITER_W-1:0] r_iter;

    // Output register
    logic                       r_o_valid;
    logic signed [SAMPLE_W-1:0] r_average;
    logic [CNT_W-1:0]           r_fill;
    logic                       r_restarted;

    // Ring port
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic signed [SAMPLE_W-1:0] ram_rdata;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len  <= WIN_LEN_RST;
            r_jump_thr <= JUMP_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WINDOW_LEN: r_win_len  <= i_cfg_wdata[CNT_W-1:0];
                CFG_JUMP_THR:   r_jump_thr <= i_cfg_wdata;
                default:        r_jump_thr <= r_jump_thr;
            endcase
        end
    end

    // Effective window length: zero means one, capped at the usable maximum
    logic [CNT_W-1:0] eff_len;
    always_comb begin
        if (r_win_len == '0) begin
            eff_len = CNT_W'(1);
        end else if (32'(r_win_len) > CNT_MAX) begin
            eff_len = CNT_W'(CNT_MAX);
        end else begin
            eff_len = r_win_len;
        end
    end

    // Jump test: exact 33-bit difference against the newest sample
    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0]        diff_mag;
    logic                     jump;
    always_comb begin
        diff     = {r_sample[SAMPLE_W-1], r_sample} - {r_newest[SAMPLE_W-1], r_newest};
        diff_mag = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
        jump     = (r_count != '0) && (diff_mag > {2'b00, r_jump_thr});
    end

    // Window update after the decision
    logic [CNT_W-1:0]        held_a;
    logic [IDX_W-1:0]        oldest_a;
    logic [IDX_W-1:0]        oldest_inc;
    logic signed [SUM_W-1:0] sum_a;
    logic [ADD_W-1:0]        widx_sum;
    always_comb begin
        oldest_inc = (32'(r_oldest) == WINDOW_MAX - 1) ? '0 : r_oldest + IDX_W'(1);
        if (r_restart) begin
            held_a   = '0;
            oldest_a = '0;
            sum_a    = '0;
        end else if (r_drop) begin
            held_a   = r_count - CNT_W'(1);
            oldest_a = oldest_inc;
            sum_a    = r_sum - SUM_W'(ram_rdata);
        end else begin
            held_a   = r_count;
            oldest_a = r_oldest;
            sum_a    = r_sum;
        end
        // slot after the newest one, wrapped once around the ring
        widx_sum = ADD_W'(oldest_a) + ADD_W'(held_a);
        if (32'(widx_sum) >= WINDOW_MAX) begin
            widx_sum = widx_sum - ADD_W'(WINDOW_MAX);
        end
        ram_waddr = widx_sum[IDX_W-1:0];
        ram_we    = i_cmd.update;
    end

    // Window state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_oldest <= '0;
            r_newest <= '0;
        end else if (i_cmd.update) begin
            r_sum    <= sum_a + SUM_W'(r_sample);
            r_count  <= held_a + CNT_W'(1);
            r_oldest <= oldest_a;
            r_newest <= r_sample;
        end
    end

    // Captured sample and decision
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
        if (i_cmd.test) begin
            r_restart <= jump;
            r_drop    <= r_count >= eff_len;
        end
    end

    // Ring holding the window samples
    jrma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_sample),
        .i_raddr (r_oldest),
        .o_rdata (ram_rdata)
    );

    // Restoring divider: one quotient bit per cycle on the sum magnitude
    logic [REM_W-1:0] rem_sh;
    logic             rem_ge;
    always_comb begin
        rem_sh = {r_rem[REM_W-2:0], r_quo[SUM_W-1]};
        rem_ge = rem_sh >= REM_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
        end else if (i_cmd.div_load) begin
            r_iter <= '0;
        end else if (i_cmd.div_step) begin
            r_iter <= r_iter + ITER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg <= r_sum[SUM_W-1];
            r_quo <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sh - REM_W'(r_count) : rem_sh;
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
        end
    end

    assign o_sts.div_last = (32'(r_iter) == SUM_W - 1);
    assign o_sts.out_free = !r_o_valid || i_ready;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_average   <= r_neg ? SAMPLE_W'(-r_quo) : r_quo[SAMPLE_W-1:0];
            r_fill      <= r_count;
            r_restarted <= r_restart;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_average    = r_average;
    assign o_fill_count = r_fill;
    assign o_restarted  = r_restarted;

endmodule

/* sv/jump_reset_moving_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jump_reset_moving_average
// Sliding-window average of signed Q16.16 samples; the window restarts when
// a sample steps away from the newest one by more than the jump threshold.
// ----------------------------------------------------------------------------
// Each accepted sample produces one transaction on the output: the window sum
// divided by the fill count (truncated toward zero), the fill count and a
// restart flag. One sample is processed at a time; from acceptance to a valid
// result it goes through the jump test and ring read, the window update, the
// priming of the divider, the bit-serial restoring divider, which sets the
// rate, and the load of the output register, which waits until that register
// is free. The next sample is accepted in the cycle after the result is
// registered, even while that result is still waiting to be taken. The window
// length register holds 0 to 15; zero acts as one and larger values are capped
// at the ring depth WINDOW_MAX.
// Configuration writes must be made only while no sample is in flight.
module jump_reset_moving_average
    import jrma_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [THR_W-1:0]           i_cfg_wdata,
    // input channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    // output channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_average,
    output logic [CNT_W-1:0]           o_fill_count,
    output logic                       o_restarted
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    jrma_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath
    jrma_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_average    (o_average),
        .o_fill_count (o_fill_count),
        .o_restarted  (o_restarted),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the jump-resetting moving average. Samples go in
// through a valid/ready channel and each result is compared with a cycle-free
// window tracker kept alongside the block. A directed opening covers the field
// extremes, the jump boundary and window length corner values; random phases
// then step through several window and threshold settings under varied idling.
// ----------------------------------------------------------------------------

// Expected result of one sample
typedef struct {
    logic signed [jrma_pkg::SAMPLE_W-1:0] average;
    logic [jrma_pkg::CNT_W-1:0]           fill_count;
    logic                                 restarted;
} t_window_result;

// Tracks the window contents and queues the result each sample should give
class window_average_tracker;
    logic [jrma_pkg::CNT_W-1:0]           win_len;
    logic [jrma_pkg::THR_W-1:0]           jump_thr;
    logic signed [jrma_pkg::SAMPLE_W-1:0] ring [jrma_pkg::WINDOW_MAX_DEF];
    longint                               window_sum;
    int unsigned                          held;
    int unsigned                          oldest;
    logic signed [jrma_pkg::SAMPLE_W-1:0] newest;
    t_window_result                       pending_averages [$];
    int                                   mismatches;

    function new();
        win_len    = jrma_pkg::WIN_LEN_RST;
        jump_thr   = jrma_pkg::JUMP_THR_RST;
        window_sum = 0;
        held       = 0;
        oldest     = 0;
        newest     = '0;
        mismatches = 0;
        foreach (ring[i]) ring[i] = '0;
    endfunction

    function void write_reg(logic idx, logic [jrma_pkg::THR_W-1:0] val);
        case (idx)
            jrma_pkg::CFG_WINDOW_LEN: win_len  = val[jrma_pkg::CNT_W-1:0];
            jrma_pkg::CFG_JUMP_THR:   jump_thr = val;
        endcase
    endfunction

    // Apply one accepted sample to the window and queue its result
    function void note_sample(logic signed [jrma_pkg::SAMPLE_W-1:0] s);
        int unsigned    lim;
        longint         step;
        t_window_result res;
        lim = (win_len == 0) ? 1 :
              (win_len > jrma_pkg::WINDOW_MAX_DEF) ? jrma_pkg::WINDOW_MAX_DEF : win_len;
        res.restarted = 1'b0;
        // jump test only once the window holds something
        if (held > 0) begin
            step = longint'(s) - longint'(newest);
            if (step < 0) step = -step;
            if (step > longint'(jump_thr)) res.restarted = 1'b1;
        end
        if (res.restarted) begin
            held       = 0;
            window_sum = 0;
            oldest     = 0;
        end else if (held + 1 > lim) begin
            window_sum -= longint'(ring[oldest]);
            oldest = (oldest + 1) % jrma_pkg::WINDOW_MAX_DEF;
            held--;
        end
        ring[(oldest + held) % jrma_pkg::WINDOW_MAX_DEF] = s;
        window_sum += longint'(s);
        held++;
        newest = s;
        // SV integer division truncates toward zero
        res.average    = jrma_pkg::SAMPLE_W'(window_sum / longint'(held));
        res.fill_count = jrma_pkg::CNT_W'(held);
        pending_averages = {pending_averages, res};
    endfunction

    // Compare one accepted result with the oldest outstanding expectation
    function void check_average(logic signed [jrma_pkg::SAMPLE_W-1:0] avg,
                                logic [jrma_pkg::CNT_W-1:0] fill, logic rs);
        t_window_result res;
        if (pending_averages.size() == 0) begin
            $error("unexpected result transaction: average %0d fill_count %0d", avg, fill);
            mismatches++;
            return;
        end
        res = pending_averages.pop_front();
        if (avg !== res.average) begin
            $error("average: expected %0d, got %0d", res.average, avg);
            mismatches++;
        end
        if (fill !== res.fill_count) begin
            $error("fill_count: expected %0d, got %0d", res.fill_count, fill);
            mismatches++;
        end
        if (rs !== res.restarted) begin
            $error("restarted: expected %0b, got %0b", res.restarted, rs);
            mismatches++;
        end
    endfunction
endclass

module tb;
    import jrma_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 50;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 94;
    localparam int PRESSURE_PH   = 2;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_cfg_we     = 1'b0;
    logic                       i_cfg_addr   = CFG_WINDOW_LEN;
    logic [THR_W-1:0]           i_cfg_wdata  = '0;
    logic                       i_valid      = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample     = '0;
    logic                       o_valid;
    logic                       i_ready      = 1'b0;
    logic signed [SAMPLE_W-1:0] o_average;
    logic [CNT_W-1:0]           o_fill_count;
    logic                       o_restarted;

    window_average_tracker tracker = new();

    int unsigned                send_idle_pct = 0;
    int unsigned                recv_stall_pct = 0;
    int unsigned                hold_requests = 0;
    int unsigned                holds_done = 0;
    int unsigned                hold_left = 0;
    int unsigned                cycle_count = 0;
    logic signed [SAMPLE_W-1:0] last_sent = '0;
    logic [THR_W-1:0]           cur_thr = JUMP_THR_RST;

    // Random phase settings: window length, threshold, idling
    int unsigned phase_win [N_PHASES] = '{4, 8, 2, 9, 1, 15, 7, 5};
    int unsigned phase_thr [N_PHASES] = '{655, 65536, 32'h7FFF_FFFF, 1000, 0, 50000, 3,
                                          32'h0010_0000};
    t_idle       phase_idle [N_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                           IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    t_idle       cur_idle = IDLE_NONE;

    jump_reset_moving_average u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_average    (o_average),
        .o_fill_count (o_fill_count),
        .o_restarted  (o_restarted)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Transactions on both channels, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) tracker.note_sample(i_sample);
            if (o_valid && i_ready) tracker.check_average(o_average, o_fill_count, o_restarted);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one sample and hold it until taken; returns at a falling edge
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        last_sent = s;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Both registers, back to back; called at a falling edge with the block idle
    task automatic program_window(input logic [CNT_W-1:0] win, input logic [THR_W-1:0] thr);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_WINDOW_LEN;
        i_cfg_wdata <= THR_W'(win);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_JUMP_THR;
        i_cfg_wdata <= thr;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.write_reg(CFG_WINDOW_LEN, THR_W'(win));
        tracker.write_reg(CFG_JUMP_THR, thr);
        cur_thr = thr;
    endtask

    // Wait for every outstanding result, then let the block settle
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (tracker.pending_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic void apply_idle(input t_idle mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 64 : (mode == IDLE_BOTH) ? 36 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 64 : (mode == IDLE_BOTH) ? 36 : 0;
    endfunction

    // Mostly steps within the threshold, some on and just past it, some noise
    function automatic logic signed [SAMPLE_W-1:0] next_sample(
            input logic signed [SAMPLE_W-1:0] prev, input logic [THR_W-1:0] thr);
        longint      v;
        longint      t;
        int unsigned pick;
        t    = longint'(thr);
        pick = $urandom_range(99);
        if (pick < 70)
            v = longint'(prev) + longint'($urandom_range(32'(2 * t))) - t;
        else if (pick < 78)
            v = $urandom_range(1) ? longint'(prev) + t : longint'(prev) - t;
        else if (pick < 86)
            v = $urandom_range(1) ? longint'(prev) + t + 1 : longint'(prev) - t - 1;
        else
            return $urandom;
        if (v > longint'(32'sh7FFF_FFFF)) v = longint'(32'sh7FFF_FFFF);
        if (v < -longint'(64'h8000_0000)) v = -longint'(64'h8000_0000);
        return SAMPLE_W'(v);
    endfunction

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty window, exact threshold step, one past it,
        // then fill past the window length
        send_sample(0);
        send_sample(655);
        send_sample(1311);
        send_sample(656);
        send_sample(700);
        send_sample(800);
        send_sample(900);
        send_sample(1000);
        send_sample(1100);
        send_sample(1200);
        send_sample(1300);
        wait_for_drain();

        // Length above the ring depth, widest threshold, sample extremes and
        // negative averages that need truncating
        program_window(4'd15, 31'h7FFF_FFFF);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh8000_0000);
        send_sample(-3);
        send_sample(-4);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh7FFF_FFFF);
        wait_for_drain();

        // Length zero acts as one; zero threshold
        program_window(4'd0, 31'd0);
        send_sample(5);
        send_sample(5);
        send_sample(6);
        send_sample(-7);
        wait_for_drain();

        // Random phases
        for (int p = 0; p < N_PHASES; p++) begin
            program_window(CNT_W'(phase_win[p]), THR_W'(phase_thr[p]));
            cur_idle = phase_idle[p];
            if (p == PRESSURE_PH) hold_requests++;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // occasional stretches with no idling at all
                if (k % 20 == 0) begin
                    if ($urandom_range(3) == 0) apply_idle(IDLE_NONE);
                    else apply_idle(cur_idle);
                end
                send_sample(next_sample(last_sent, cur_thr));
            end
            apply_idle(IDLE_NONE);
            wait_for_drain();
        end

        if (tracker.pending_averages.size() != 0) begin
            $error("%0d results never arrived", tracker.pending_averages.size());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* jump_reset_moving_average.f */
sv/jrma_pkg.sv
sv/jrma_ram.sv
sv/jrma_ctrl.sv
sv/jrma_dp.sv
sv/jump_reset_moving_average.sv
dv/tb.sv
